FILE: src/row_convolution_replicate_edge_top_assert.svh
// Assertion macros used by the row convolution issue logic.
`ifndef ROW_CONVOLUTION_REPLICATE_EDGE_TOP_ASSERT_SVH
`define ROW_CONVOLUTION_REPLICATE_EDGE_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RCRE_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcre: same-cycle check failed");

// next-cycle implication, disabled in reset
`define RCRE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcre: next-cycle check failed");

`endif

FILE: src/rcre_pkg.sv
// Shared types and constants of the row convolution block.
`default_nettype none
package rcre_pkg;

   localparam int COLUMN_BITS = 12;
   localparam int TAP_BITS    = 16;
   localparam int RADIUS_BITS = 3;
   localparam int INDEX_BITS  = 3;

   localparam logic [INDEX_BITS-1:0] REG_ROW_WIDTH = 3'd0;
   localparam logic [INDEX_BITS-1:0] REG_RADIUS    = 3'd1;
   localparam logic [INDEX_BITS-1:0] REG_SHIFT     = 3'd2;
   localparam logic [INDEX_BITS-1:0] REG_TAPS_BASE = 3'd3;

   typedef struct packed {
      logic                   valid;
      logic [COLUMN_BITS-1:0] column;
      logic                   row_end;
      logic                   last_of_run;
   } job_type;

endpackage
`default_nettype wire

FILE: src/rcre_issue.sv
// Window shift line, column tracking and per-output job issue.
`default_nettype none
`include "row_convolution_replicate_edge_top_assert.svh"
module rcre_issue #(
   parameter int PIXEL_BITS = 16,
   parameter int NTAPS      = 15,
   parameter int COL_W      = 12
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                en,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [PIXEL_BITS-1:0]              pixel,
   input  wire  [COL_W-1:0]                   w_last,
   input  wire  [rcre_pkg::RADIUS_BITS-1:0]   r_eff,
   output rcre_pkg::job_type                  job_ff,
   output logic [NTAPS*PIXEL_BITS-1:0]        samples_ff
);
   localparam int SEL_W = $clog2(NTAPS);

   logic [NTAPS*PIXEL_BITS-1:0] win_ff;
   logic [COL_W-1:0] in_col_ff, out_col_ff, lastcol_ff, c_ff;
   logic             busy_ff, rowend_ff;
   logic [2:0]       cnt_ff;

   logic             issue, at_end, final_job, accept, last, has;
   logic [COL_W-1:0] oc_issue, oc_cur, c_minus_r, lastcol_in;
   logic             c_ge_r;
   rcre_pkg::job_type           job_in;
   logic [NTAPS*PIXEL_BITS-1:0] samples_in;

   assign issue     = busy_ff && en;
   assign at_end    = out_col_ff == lastcol_ff;
   assign final_job = at_end || (cnt_ff == 3'd7);
   assign oc_issue  = (final_job && rowend_ff) ? '0 : out_col_ff + 1'b1;
   assign oc_cur    = issue ? oc_issue : out_col_ff;
   assign req_ready = !busy_ff || (issue && final_job);
   assign accept    = req_valid && req_ready;

   assign last      = in_col_ff >= w_last;
   assign c_ge_r    = in_col_ff >= COL_W'(r_eff);
   assign c_minus_r = in_col_ff - COL_W'(r_eff);
   assign lastcol_in = last ? in_col_ff : c_minus_r;
   assign has = last ? (oc_cur <= in_col_ff) : (c_ge_r && (oc_cur <= c_minus_r));

   // replicate-edge tap selection: distance back from the newest pixel
   always_comb begin
      logic [COL_W:0]   sum, x, d, cc;
      logic [SEL_W-1:0] sel;
      samples_in = '0;
      cc = {1'b0, c_ff};
      for (int k = 0; k < NTAPS; k++) begin
         sum = {1'b0, out_col_ff} + (COL_W+1)'(k);
         x   = (sum < (COL_W+1)'(r_eff)) ? '0 : sum - (COL_W+1)'(r_eff);
         if (x > cc) x = cc;
         d   = cc - x;
         sel = (d > (COL_W+1)'(NTAPS-1)) ? SEL_W'(NTAPS-1) : SEL_W'(d);
         samples_in[k*PIXEL_BITS +: PIXEL_BITS] = win_ff[sel*PIXEL_BITS +: PIXEL_BITS];
      end
   end

   always_comb begin
      job_in.valid       = issue;
      job_in.column      = rcre_pkg::COLUMN_BITS'(out_col_ff);
      job_in.row_end     = rowend_ff && at_end;
      job_in.last_of_run = final_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff.valid <= 1'b0;
      end else if (en) begin
         job_ff <= job_in;
      end
      if (en) begin
         samples_ff <= samples_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff     <= '0;
         in_col_ff  <= '0;
         out_col_ff <= '0;
         busy_ff    <= 1'b0;
         cnt_ff     <= '0;
         rowend_ff  <= 1'b0;
         lastcol_ff <= '0;
         c_ff       <= '0;
      end else begin
         if (issue) begin
            out_col_ff <= oc_issue;
            cnt_ff     <= cnt_ff + 1'b1;
            if (final_job) busy_ff <= 1'b0;
         end
         if (accept) begin
            win_ff    <= {win_ff[(NTAPS-1)*PIXEL_BITS-1:0], pixel};
            in_col_ff <= last ? '0 : in_col_ff + 1'b1;
            if (has) begin
               busy_ff    <= 1'b1;
               cnt_ff     <= '0;
               lastcol_ff <= lastcol_in;
               rowend_ff  <= last;
               c_ff       <= in_col_ff;
            end else if (last) begin
               out_col_ff <= '0;
            end
         end
      end
   end

   `RCRE_ASSERT_IMPL(a_rowend_is_final, clock, reset, job_ff.valid && job_ff.row_end, job_ff.last_of_run)
   `RCRE_ASSERT_IMPL(a_issue_in_range, clock, reset, issue, out_col_ff <= lastcol_ff)
   `RCRE_ASSERT_NEXT(a_row_restart, clock, reset, issue && final_job && rowend_ff, out_col_ff == '0)
endmodule
`default_nettype wire

FILE: src/rcre_cell.sv
// One multiply-accumulate cell of the systolic tap chain.
`default_nettype none
module rcre_cell #(
   parameter int PIXEL_BITS = 16,
   parameter int NTAPS      = 15,
   parameter int K          = 0,
   parameter int ACC_BITS   = 37
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  en,
   input  wire  rcre_pkg::job_type              job_in,
   input  wire  [NTAPS*PIXEL_BITS-1:0]          samples_in,
   input  wire  signed [ACC_BITS-1:0]           acc_in,
   input  wire  signed [rcre_pkg::TAP_BITS-1:0] tap,
   output rcre_pkg::job_type                    job_ff,
   output logic [NTAPS*PIXEL_BITS-1:0]          samples_ff,
   output logic signed [ACC_BITS-1:0]           acc_ff
);
   logic signed [PIXEL_BITS+rcre_pkg::TAP_BITS:0] prod;
   logic signed [ACC_BITS-1:0]                    acc_in_sum;

   assign prod = tap * $signed({1'b0, samples_in[K*PIXEL_BITS +: PIXEL_BITS]});
   assign acc_in_sum = acc_in + ACC_BITS'(prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff.valid <= 1'b0;
      end else if (en) begin
         job_ff <= job_in;
      end
      if (en) begin
         samples_ff <= samples_in;
         acc_ff     <= acc_in_sum;
      end
   end
endmodule
`default_nettype wire

FILE: src/row_convolution_replicate_edge_top.sv
// Top level of the replicate-edge row convolution filter.
//
//  port group | dir | payload
//  req_*      | in  | tdata[PIXEL_BITS-1:0] = pixel
//  rsp_*      | out | tdata = filtered_pixel[15:0], column[27:16]; tuser = row_end;
//             |     | tlast = last_of_run
//  csr_*      | in  | write enable, register index, 64-bit data
//
// Unless rsp stalls, one pixel per cycle is taken while each pixel yields at most one output.
// A row end yields up to R+1 outputs (at most 8), issued one per cycle while
// rsp is not stalled and req_tready is low; the issue sequencer is the bottleneck.
// Each result passes from the issue register through the tap cell chain to the output register.
// Reset is synchronous; it clears columns, window and config to defaults.
// A stalled rsp side freezes the whole chain; req stalls once a pixel with
// pending outputs is waiting to issue.
`default_nettype none
module row_convolution_replicate_edge_top #(
   parameter int PIXEL_BITS = 16,
   parameter int MAX_RADIUS = 7,
   parameter int MAX_WIDTH  = 4096
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [PIXEL_BITS-1:0]             req_tdata,   // pixel
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [31:0]                       rsp_tdata,   // filtered_pixel, column, pad
   output logic                              rsp_tuser,   // row_end
   output logic                              rsp_tlast,   // last_of_run
   input  wire                               csr_we,
   input  wire  [rcre_pkg::INDEX_BITS-1:0]   csr_index,
   input  wire  [63:0]                       csr_wdata
);
   localparam int NTAPS    = 2 * MAX_RADIUS + 1;
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ACC_BITS = PIXEL_BITS + rcre_pkg::TAP_BITS + 1 + $clog2(NTAPS + 1);

   // configuration registers
   logic [12:0] width_ff;
   logic [rcre_pkg::RADIUS_BITS-1:0] radius_ff;
   logic [4:0]  shift_ff;
   logic signed [rcre_pkg::TAP_BITS-1:0] taps_ff [NTAPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd4096;
         radius_ff <= '0;
         shift_ff  <= '0;
         for (int k = 0; k < NTAPS; k++) begin
            taps_ff[k] <= (k == 0) ? 16'sd1 : 16'sd0;
         end
      end else if (csr_we) begin
         case (csr_index)
            rcre_pkg::REG_ROW_WIDTH: width_ff  <= csr_wdata[12:0];
            rcre_pkg::REG_RADIUS:    radius_ff <= csr_wdata[rcre_pkg::RADIUS_BITS-1:0];
            rcre_pkg::REG_SHIFT:     shift_ff  <= csr_wdata[4:0];
            default: begin
               // tap registers hold four 16-bit fields each, tap 0 lowest
               for (int k = 0; k < NTAPS; k++) begin
                  if (csr_index == rcre_pkg::INDEX_BITS'(rcre_pkg::REG_TAPS_BASE + (k >> 2)))
                     taps_ff[k] <= csr_wdata[(k & 3)*16 +: 16];
               end
            end
         endcase
      end
   end

   // effective settings: width clamped to 1..MAX_WIDTH, radius to MAX_RADIUS
   logic [COL_W-1:0] w_last;
   logic [rcre_pkg::RADIUS_BITS-1:0] r_eff;
   logic signed [rcre_pkg::TAP_BITS-1:0] tap_eff [NTAPS];

   always_comb begin
      if (width_ff == '0)
         w_last = '0;
      else if (32'(width_ff) > MAX_WIDTH)
         w_last = COL_W'(MAX_WIDTH - 1);
      else
         w_last = COL_W'(width_ff - 13'd1);
      r_eff = (32'(radius_ff) > MAX_RADIUS) ? rcre_pkg::RADIUS_BITS'(MAX_RADIUS) : radius_ff;
      // taps past 2R do not contribute
      for (int k = 0; k < NTAPS; k++) begin
         tap_eff[k] = (k <= 2 * int'(r_eff)) ? taps_ff[k] : '0;
      end
   end

   // chain advances whenever the output register can take a transaction
   logic en;
   logic rsp_valid_ff;
   assign en = !rsp_valid_ff || rsp_tready;

   rcre_pkg::job_type           job_c   [NTAPS+1];
   logic [NTAPS*PIXEL_BITS-1:0] samp_c  [NTAPS+1];
   logic signed [ACC_BITS-1:0]  acc_c   [NTAPS+1];

   assign acc_c[0] = '0;

   rcre_issue #(
      .PIXEL_BITS (PIXEL_BITS),
      .NTAPS      (NTAPS),
      .COL_W      (COL_W)
   ) u_issue (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .pixel      (req_tdata),
      .w_last     (w_last),
      .r_eff      (r_eff),
      .job_ff     (job_c[0]),
      .samples_ff (samp_c[0])
   );

   for (genvar k = 0; k < NTAPS; k++) begin : g_cell
      rcre_cell #(
         .PIXEL_BITS (PIXEL_BITS),
         .NTAPS      (NTAPS),
         .K          (k),
         .ACC_BITS   (ACC_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .job_in     (job_c[k]),
         .samples_in (samp_c[k]),
         .acc_in     (acc_c[k]),
         .tap        (tap_eff[k]),
         .job_ff     (job_c[k+1]),
         .samples_ff (samp_c[k+1]),
         .acc_ff     (acc_c[k+1])
      );
   end

   // normalise: arithmetic shift, keep the low pixel bits
   logic signed [ACC_BITS-1:0] shifted;
   logic [15:0] pix_out_ff;
   logic [rcre_pkg::COLUMN_BITS-1:0] col_ff;
   logic row_end_ff, last_ff;

   assign shifted = acc_c[NTAPS] >>> shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= job_c[NTAPS].valid;
      end
      if (en) begin
         pix_out_ff <= 16'(shifted[PIXEL_BITS-1:0]);
         col_ff     <= job_c[NTAPS].column;
         row_end_ff <= job_c[NTAPS].row_end;
         last_ff    <= job_c[NTAPS].last_of_run;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, col_ff, pix_out_ff};
   assign rsp_tuser  = row_end_ff;
   assign rsp_tlast  = last_ff;
endmodule
`default_nettype wire
